@@ rtl/tpr_pkg.sv @@
// shared types and constants for the triangle point-to-reference block
`timescale 1ns / 1ps
package tpr_pkg;

   localparam int COORD_BITS     = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int DIFF_BITS      = COORD_BITS + 1;
   localparam int PROD_BITS      = 2 * DIFF_BITS;
   localparam int SUM_BITS       = PROD_BITS + 1;
   localparam int QUO_BITS       = COORD_BITS + 1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] v0_x;
      logic signed [COORD_BITS-1:0] v0_y;
      logic signed [COORD_BITS-1:0] v1_x;
      logic signed [COORD_BITS-1:0] v1_y;
      logic signed [COORD_BITS-1:0] v2_x;
      logic signed [COORD_BITS-1:0] v2_y;
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] ref_u;
      logic signed [COORD_BITS-1:0] ref_v;
      logic                         singular;
   } rsp_type;

   // per-lane control that travels with the data
   typedef struct packed {
      logic valid;
      logic singular;
      logic neg;
      logic ovf;
   } ctl_type;

endpackage

@@ rtl/triangle_point_to_reference.sv @@
// top level: pull a physical point back to reference-triangle coordinates
`timescale 1ns / 1ps
// Each word on req_ carries three triangle vertices and one point in signed
// Q(FRAC_BITS) fixed point; each word on rsp_ gives the point's reference
// coordinates (ref_u, ref_v), rounded to nearest with ties away from zero and
// saturated, plus a singular flag that is set, with zero coordinates, when the
// triangle is degenerate. The block takes one word per clock and has these
// stages: five front
// stages (differences, six 33x33 products, cross sums, magnitudes, overflow
// check), one restoring division stage per quotient bit for COORD_BITS + 1
// bits, and the rounding stage that loads the output register. The whole pipe
// advances together; it holds when a response waits under rsp_stall, and
// req_stall follows that. There is no state and no configuration.
module triangle_point_to_reference #(
   parameter int FRAC_BITS = tpr_pkg::FRAC_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tpr_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tpr_pkg::rsp_type rsp_word
);
   import tpr_pkg::*;

   // remainder width covers the scaled numerator and the widest shifted divisor
   localparam int WORK_BITS = SUM_BITS + QUO_BITS + FRAC_BITS;

   logic en;

   // one chain of division stages per coordinate, index 0 is the front output
   ctl_type              cu [QUO_BITS+1];
   ctl_type              cv [QUO_BITS+1];
   logic [WORK_BITS-1:0] ru [QUO_BITS+1];
   logic [WORK_BITS-1:0] rv [QUO_BITS+1];
   logic [SUM_BITS-1:0]  du [QUO_BITS+1];
   logic [SUM_BITS-1:0]  dv [QUO_BITS+1];
   logic [QUO_BITS-1:0]  qu [QUO_BITS+1];
   logic [QUO_BITS-1:0]  qv [QUO_BITS+1];

   logic signed [COORD_BITS-1:0] ref_u_in, ref_v_in;
   logic                         rsp_valid_ff;
   rsp_type                      rsp_word_ff;

   // the pipe moves unless a finished word is held by the receiver
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   tpr_front #(
      .FRAC_BITS (FRAC_BITS),
      .WORK_BITS (WORK_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_word  (req_word),
      .ctl_u    (cu[0]),
      .ctl_v    (cv[0]),
      .num_u    (ru[0]),
      .num_v    (rv[0]),
      .den      (du[0])
   );
   assign dv[0] = du[0];
   assign qu[0] = '0;
   assign qv[0] = '0;

   // quotient bits from the top down, one bit per stage
   for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
      tpr_div_step #(
         .WORK_BITS (WORK_BITS),
         .SHIFT     (QUO_BITS - 1 - k)
      ) u_step_u (
         .clock (clock), .reset (reset), .en (en),
         .ctl_i (cu[k]),   .rem_i (ru[k]),   .den_i (du[k]),   .quo_i (qu[k]),
         .ctl_o (cu[k+1]), .rem_o (ru[k+1]), .den_o (du[k+1]), .quo_o (qu[k+1])
      );
      tpr_div_step #(
         .WORK_BITS (WORK_BITS),
         .SHIFT     (QUO_BITS - 1 - k)
      ) u_step_v (
         .clock (clock), .reset (reset), .en (en),
         .ctl_i (cv[k]),   .rem_i (rv[k]),   .den_i (dv[k]),   .quo_i (qv[k]),
         .ctl_o (cv[k+1]), .rem_o (rv[k+1]), .den_o (dv[k+1]), .quo_o (qv[k+1])
      );
   end

   tpr_round #(.WORK_BITS (WORK_BITS)) u_round_u (
      .ctl_i   (cu[QUO_BITS]),
      .rem_i   (ru[QUO_BITS]),
      .den_i   (du[QUO_BITS]),
      .quo_i   (qu[QUO_BITS]),
      .coord_o (ref_u_in)
   );

   tpr_round #(.WORK_BITS (WORK_BITS)) u_round_v (
      .ctl_i   (cv[QUO_BITS]),
      .rem_i   (rv[QUO_BITS]),
      .den_i   (dv[QUO_BITS]),
      .quo_i   (qv[QUO_BITS]),
      .coord_o (ref_v_in)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= cu[QUO_BITS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_word_ff <= '{ref_u: ref_u_in, ref_v: ref_v_in,
                          singular: cu[QUO_BITS].singular};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // a degenerate triangle always reports zero coordinates
   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.singular |-> rsp_word.ref_u == '0 && rsp_word.ref_v == '0)
      else $error("singular word with nonzero coordinates");

   // both coordinate lanes keep the same valid flag, and the same singular flag on a word
   a_lanes_agree : assert property (@(posedge clock) disable iff (reset)
      cu[QUO_BITS].valid == cv[QUO_BITS].valid
      && (!cu[QUO_BITS].valid || cu[QUO_BITS].singular == cv[QUO_BITS].singular))
      else $error("coordinate lanes out of step");

   // nothing comes out in the cycle after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

@@ rtl/tpr_front.sv @@
// edge matrix, cross products, magnitudes and overflow check
`timescale 1ns / 1ps
module tpr_front #(
   parameter int FRAC_BITS = 16,
   parameter int WORK_BITS = 116
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  tpr_pkg::req_type                in_word,
   output tpr_pkg::ctl_type                ctl_u,
   output tpr_pkg::ctl_type                ctl_v,
   output logic [WORK_BITS-1:0]            num_u,
   output logic [WORK_BITS-1:0]            num_v,
   output logic [tpr_pkg::SUM_BITS-1:0]    den
);
   import tpr_pkg::*;

   localparam int MSB = COORD_BITS - 1;

   // stage 1: differences
   logic                        v1_ff;
   logic signed [DIFF_BITS-1:0] a00_ff, a01_ff, a10_ff, a11_ff, b0_ff, b1_ff;
   // stage 2: products
   logic                        v2_ff;
   logic signed [PROD_BITS-1:0] p_det0_ff, p_det1_ff, p_u0_ff, p_u1_ff, p_v0_ff, p_v1_ff;
   // stage 3: determinant and numerators
   logic                        v3_ff;
   logic signed [SUM_BITS-1:0]  det_ff, nu_ff, nv_ff;
   // stage 4: magnitudes and signs
   ctl_type                     c4u_ff, c4v_ff;
   logic [SUM_BITS-1:0]         mdet_ff, mu_ff, mv_ff;
   // stage 5: overflow check
   ctl_type                     c5u_ff, c5v_ff;
   logic [WORK_BITS-1:0]        n5u_ff, n5v_ff;
   logic [SUM_BITS-1:0]         d5_ff;

   logic [SUM_BITS-1:0]  mdet_in, mu_in, mv_in;
   logic [WORK_BITS-1:0] nsu_in, nsv_in, dlim_in;
   ctl_type              c4u_in, c4v_in;

   always_comb begin
      mdet_in = det_ff[SUM_BITS-1] ? SUM_BITS'(-det_ff) : SUM_BITS'(det_ff);
      mu_in   = nu_ff[SUM_BITS-1] ? SUM_BITS'(-nu_ff) : SUM_BITS'(nu_ff);
      mv_in   = nv_ff[SUM_BITS-1] ? SUM_BITS'(-nv_ff) : SUM_BITS'(nv_ff);
      c4u_in  = '{valid: v3_ff, singular: (det_ff == '0),
                  neg: nu_ff[SUM_BITS-1] ^ det_ff[SUM_BITS-1], ovf: 1'b0};
      c4v_in  = '{valid: v3_ff, singular: (det_ff == '0),
                  neg: nv_ff[SUM_BITS-1] ^ det_ff[SUM_BITS-1], ovf: 1'b0};
      nsu_in  = WORK_BITS'(mu_ff) << FRAC_BITS;
      nsv_in  = WORK_BITS'(mv_ff) << FRAC_BITS;
      dlim_in = WORK_BITS'(mdet_ff) << QUO_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         c4u_ff <= '0;
         c4v_ff <= '0;
         c5u_ff <= '0;
         c5v_ff <= '0;
      end else if (en) begin
         v1_ff  <= in_valid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         c4u_ff <= c4u_in;
         c4v_ff <= c4v_in;
         c5u_ff <= '{valid: c4u_ff.valid, singular: c4u_ff.singular,
                     neg: c4u_ff.neg, ovf: (nsu_in >= dlim_in)};
         c5v_ff <= '{valid: c4v_ff.valid, singular: c4v_ff.singular,
                     neg: c4v_ff.neg, ovf: (nsv_in >= dlim_in)};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a00_ff <= {in_word.v1_x[MSB], in_word.v1_x} - {in_word.v0_x[MSB], in_word.v0_x};
         a01_ff <= {in_word.v2_x[MSB], in_word.v2_x} - {in_word.v0_x[MSB], in_word.v0_x};
         a10_ff <= {in_word.v1_y[MSB], in_word.v1_y} - {in_word.v0_y[MSB], in_word.v0_y};
         a11_ff <= {in_word.v2_y[MSB], in_word.v2_y} - {in_word.v0_y[MSB], in_word.v0_y};
         b0_ff  <= {in_word.point_x[MSB], in_word.point_x}
                   - {in_word.v0_x[MSB], in_word.v0_x};
         b1_ff  <= {in_word.point_y[MSB], in_word.point_y}
                   - {in_word.v0_y[MSB], in_word.v0_y};
         p_det0_ff <= PROD_BITS'(a00_ff) * PROD_BITS'(a11_ff);
         p_det1_ff <= PROD_BITS'(a01_ff) * PROD_BITS'(a10_ff);
         p_u0_ff   <= PROD_BITS'(b0_ff) * PROD_BITS'(a11_ff);
         p_u1_ff   <= PROD_BITS'(a01_ff) * PROD_BITS'(b1_ff);
         p_v0_ff   <= PROD_BITS'(a00_ff) * PROD_BITS'(b1_ff);
         p_v1_ff   <= PROD_BITS'(a10_ff) * PROD_BITS'(b0_ff);
         det_ff <= SUM_BITS'(p_det0_ff) - SUM_BITS'(p_det1_ff);
         nu_ff  <= SUM_BITS'(p_u0_ff) - SUM_BITS'(p_u1_ff);
         nv_ff  <= SUM_BITS'(p_v0_ff) - SUM_BITS'(p_v1_ff);
         mdet_ff <= mdet_in;
         mu_ff   <= mu_in;
         mv_ff   <= mv_in;
         n5u_ff  <= nsu_in;
         n5v_ff  <= nsv_in;
         d5_ff   <= mdet_ff;
      end
   end

   assign ctl_u = c5u_ff;
   assign ctl_v = c5v_ff;
   assign num_u = n5u_ff;
   assign num_v = n5v_ff;
   assign den   = d5_ff;

endmodule

@@ rtl/tpr_div_step.sv @@
// one restoring division step: one quotient bit per stage
`timescale 1ns / 1ps
module tpr_div_step #(
   parameter int WORK_BITS = 116,
   parameter int SHIFT     = 0
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  tpr_pkg::ctl_type                ctl_i,
   input  logic [WORK_BITS-1:0]            rem_i,
   input  logic [tpr_pkg::SUM_BITS-1:0]    den_i,
   input  logic [tpr_pkg::QUO_BITS-1:0]    quo_i,
   output tpr_pkg::ctl_type                ctl_o,
   output logic [WORK_BITS-1:0]            rem_o,
   output logic [tpr_pkg::SUM_BITS-1:0]    den_o,
   output logic [tpr_pkg::QUO_BITS-1:0]    quo_o
);
   import tpr_pkg::*;

   ctl_type              ctl_ff;
   logic [WORK_BITS-1:0] rem_ff, dsh;
   logic [SUM_BITS-1:0]  den_ff;
   logic [QUO_BITS-1:0]  quo_ff;
   logic                 fits;

   assign dsh  = WORK_BITS'(den_i) << SHIFT;
   assign fits = (rem_i >= dsh);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (en) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= fits ? rem_i - dsh : rem_i;
         den_ff <= den_i;
         quo_ff <= quo_i | (QUO_BITS'(fits) << SHIFT);
      end
   end

   assign ctl_o = ctl_ff;
   assign rem_o = rem_ff;
   assign den_o = den_ff;
   assign quo_o = quo_ff;

endmodule

@@ rtl/tpr_round.sv @@
// round to nearest, apply sign and saturate one coordinate
`timescale 1ns / 1ps
module tpr_round #(
   parameter int WORK_BITS = 116
) (
   input  tpr_pkg::ctl_type                ctl_i,
   input  logic [WORK_BITS-1:0]            rem_i,
   input  logic [tpr_pkg::SUM_BITS-1:0]    den_i,
   input  logic [tpr_pkg::QUO_BITS-1:0]    quo_i,
   output logic signed [tpr_pkg::COORD_BITS-1:0] coord_o
);
   import tpr_pkg::*;

   localparam logic [QUO_BITS:0]   LIMIT   = (QUO_BITS+1)'(1) << (COORD_BITS - 1);
   localparam logic [COORD_BITS-1:0] MAX_POS = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic [COORD_BITS-1:0] MIN_NEG = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic              up;
   logic [QUO_BITS:0] qr;

   always_comb begin
      // remainder stays below the divisor, so its low bits hold it all
      up = ({rem_i[SUM_BITS-1:0], 1'b0} >= {1'b0, den_i});
      qr = (QUO_BITS+1)'(quo_i) + (QUO_BITS+1)'(up);
      priority if (ctl_i.singular) begin
         coord_o = '0;
      end else if (!ctl_i.neg && (ctl_i.ovf || qr >= LIMIT)) begin
         coord_o = MAX_POS;
      end else if (ctl_i.neg && (ctl_i.ovf || qr > LIMIT)) begin
         coord_o = MIN_NEG;
      end else if (ctl_i.neg) begin
         coord_o = COORD_BITS'(-qr);
      end else begin
         coord_o = COORD_BITS'(qr);
      end
   end

endmodule

@@ dv/testbench.sv @@
// testbench for the triangle point-to-reference block
`timescale 1ns / 1ps
module testbench;
   import tpr_pkg::*;

   localparam int PIPE_CYCLES  = COORD_BITS + 8;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_WORDS = 1400;
   localparam int CALM_TAIL    = 150;   // last words go without idling

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   req_type pending_words[$];      // words still to be sent
   rsp_type expected_coords[$];    // predicted responses, oldest first
   int      fail_count = 0;
   int      cycle_count = 0;
   int      send_gap = 0;
   int      hold_gap = 0;
   bit      calm = 1'b0;           // no idling on either side
   bit      drain_hold = 1'b0;     // sender waits for every response
   bit      sent_last = 1'b0;      // current word accepted at last edge

   triangle_point_to_reference dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // 2^FRAC_BITS * num / den, rounded half away from zero, saturated
   function automatic logic signed [COORD_BITS-1:0] scaled_ratio(
         logic signed [127:0] num, logic signed [127:0] den);
      logic        neg;
      logic [127:0] n, d, q, r;
      logic [127:0] lim;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      n = n << FRAC_BITS_DEF;
      q = n / d;
      r = n - q * d;
      if ((r << 1) >= d) q = q + 1;
      lim = 128'd1 << (COORD_BITS - 1);
      if (!neg && q >= lim) return {1'b0, {(COORD_BITS-1){1'b1}}};
      if (neg && q > lim) return {1'b1, {(COORD_BITS-1){1'b0}}};
      if (neg) q = -q;
      return q[COORD_BITS-1:0];
   endfunction

   // solve the 2x2 edge system for one word
   function automatic rsp_type solve_point(req_type w);
      logic signed [127:0] x0, y0, x1, y1, x2, y2, px, py;
      logic signed [127:0] a00, a01, a10, a11, b0, b1, det;
      rsp_type res;
      x0 = w.v0_x; y0 = w.v0_y; x1 = w.v1_x; y1 = w.v1_y;
      x2 = w.v2_x; y2 = w.v2_y; px = w.point_x; py = w.point_y;
      a00 = x1 - x0; a01 = x2 - x0; a10 = y1 - y0; a11 = y2 - y0;
      b0 = px - x0; b1 = py - y0;
      det = a00 * a11 - a01 * a10;
      res = '0;
      if (det == 0) begin
         res.singular = 1'b1;
         return res;
      end
      res.ref_u = scaled_ratio(b0 * a11 - a01 * b1, det);
      res.ref_v = scaled_ratio(a00 * b1 - a10 * b0, det);
      return res;
   endfunction

   function automatic req_type make_word(logic [31:0] ax, ay, bx, by, cx, cy, qx, qy);
      req_type w;
      w.v0_x = ax; w.v0_y = ay; w.v1_x = bx; w.v1_y = by;
      w.v2_x = cx; w.v2_y = cy; w.point_x = qx; w.point_y = qy;
      return w;
   endfunction

   function automatic logic [31:0] any32();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'(signed'($urandom_range(0, 255)) - 128);
         default: return $urandom;
      endcase
   endfunction

   // small triangle near an origin, with the point mostly inside or nearby
   function automatic req_type small_triangle();
      logic signed [31:0] ox, oy, ex1, ey1, ex2, ey2, s, t;
      ox = $urandom_range(0, 1) ? $urandom : 32'(signed'($urandom_range(0, 65535 * 64)));
      oy = $urandom;
      ex1 = 32'(signed'($urandom_range(0, 2 * 655360)) - 655360);
      ey1 = 32'(signed'($urandom_range(0, 2 * 655360)) - 655360);
      ex2 = 32'(signed'($urandom_range(0, 2 * 655360)) - 655360);
      ey2 = 32'(signed'($urandom_range(0, 2 * 655360)) - 655360);
      if ($urandom_range(0, 9) == 0) begin
         // degenerate: the v0-to-v2 edge is a multiple of the v0-to-v1 edge
         s = $urandom_range(0, 4);
         ex2 = ex1 * s; ey2 = ey1 * s;
      end
      s = $urandom_range(0, 65536); t = $urandom_range(0, 65536 - s);
      return make_word(ox, oy, ox + ex1, oy + ey1, ox + ex2, oy + ey2,
                       ox + 32'((64'(ex1) * s + 64'(ex2) * t) >>> 16)
                          + 32'(signed'($urandom_range(0, 8)) - 4),
                       oy + 32'((64'(ey1) * s + 64'(ey2) * t) >>> 16));
   endfunction

   // stimulus
   initial begin
      // unit triangle at its three corners and its centroid
      pending_words.push_back(make_word(0, 0, 32'h10000, 0, 0, 32'h10000, 0, 0));
      pending_words.push_back(make_word(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 0));
      pending_words.push_back(make_word(0, 0, 32'h10000, 0, 0, 32'h10000, 0, 32'h10000));
      pending_words.push_back(make_word(0, 0, 32'h10000, 0, 0, 32'h10000, 32'h5555, 32'h5555));
      // all zero: degenerate
      pending_words.push_back(make_word(0, 0, 0, 0, 0, 0, 0, 0));
      // collinear vertices
      pending_words.push_back(make_word(0, 0, 32'h10000, 32'h10000, 32'h20000, 32'h20000,
                                        32'h30000, 5));
      // tie in rounding: 3 / 2 of one lsb
      pending_words.push_back(make_word(0, 0, 32'h20000, 0, 0, 32'h10000, 3, 0));
      pending_words.push_back(make_word(0, 0, 32'h20000, 0, 0, 32'h10000, -3, 0));
      // saturation both ways
      pending_words.push_back(make_word(0, 0, 1, 0, 0, 1, 32'h7fff_ffff, 32'h8000_0000));
      pending_words.push_back(make_word(0, 0, 1, 0, 0, 1, 32'h8000_0000, 32'h7fff_ffff));
      // extreme vertices
      pending_words.push_back(make_word(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                        32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                        32'h7fff_ffff, 32'h7fff_ffff));
      pending_words.push_back(make_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                                        32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                                        32'h8000_0000, 32'h8000_0000));
      pending_words.push_back(make_word(32'hffff_ffff, 0, 32'h7fff_ffff, 32'h8000_0000,
                                        32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
                                        32'hffff_ffff));
      // negative determinant (mirrored triangle)
      pending_words.push_back(make_word(0, 0, 0, 32'h10000, 32'h10000, 0, 32'h4000, 32'hc000));
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if ($urandom_range(0, 9) < 6)
            pending_words.push_back(small_triangle());
         else
            pending_words.push_back(make_word(any32(), any32(), any32(), any32(),
                                              any32(), any32(), any32(), any32()));
      end
   end

   // sender: new word or idle burst at the falling edge
   always @(negedge clock) begin
      if (pending_words.size() <= CALM_TAIL && !reset) calm <= 1'b1;
      if (!reset && (!req_valid || sent_last)) begin
         if (drain_hold) begin
            req_valid <= 1'b0;
            if (expected_coords.size() == 0 && !rsp_valid) drain_hold <= 1'b0;
         end else if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (pending_words.size() > 0) begin
            // one pause for a full drain midway through
            if (pending_words.size() == 700 && req_valid) begin
               req_valid <= 1'b0;
               drain_hold <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
               req_valid <= 1'b0;
               send_gap <= $urandom_range(0, 5);
            end else begin
               req_word <= pending_words.pop_front();
               req_valid <= 1'b1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
      // receiver back-pressure in bursts
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (hold_gap > 0) begin
         hold_gap <= hold_gap - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         hold_gap <= $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: record accepted words and check responses at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      sent_last <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall)
         expected_coords.push_back(solve_point(req_word));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_coords.size() == 0) begin
            $display("%t: unexpected word %h", $realtime, rsp_word);
            fail_count <= fail_count + 1;
         end else begin
            want = expected_coords.pop_front();
            if (rsp_word.ref_u !== want.ref_u || rsp_word.ref_v !== want.ref_v
                || rsp_word.singular !== want.singular) begin
               $display("%t: mismatch expected u=%h v=%h s=%b actual u=%h v=%h s=%b",
                        $realtime, want.ref_u, want.ref_v, want.singular,
                        rsp_word.ref_u, rsp_word.ref_v, rsp_word.singular);
               fail_count <= fail_count + 1;
            end
         end
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("triangle_point_to_reference test failed");
         $finish;
      end
   end

   // reset, then wait for the stream to drain
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      wait (pending_words.size() == 0 && !req_valid && expected_coords.size() == 0);
      repeat (PIPE_CYCLES + 10) @(posedge clock);
      if (fail_count == 0 && expected_coords.size() == 0)
         $display("triangle_point_to_reference test passed");
      else
         $display("triangle_point_to_reference test failed");
      $finish;
   end

endmodule
